@@ rtl/tsep_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and header layout constants for the tar stream entry parser.
// Used by every module of the block; depends on nothing.
package tsep_pkg;

	localparam int SIZE_BITS_DEF   = 36;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int OUT_SIZE_W      = 36;

	localparam logic [8:0] BLOCK_LAST = 9'd511;
	localparam logic [8:0] NAME_LEN   = 9'd100;
	localparam logic [8:0] NAME_LAST  = 9'd99;
	localparam logic [8:0] SIZE_OFF   = 9'd124;
	localparam logic [8:0] SIZE_END   = 9'd136;
	localparam logic [8:0] TYPE_OFF   = 9'd156;
	localparam logic [8:0] MAGIC_OFF  = 9'd257;
	localparam logic [8:0] MAGIC_END  = 9'd263;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [1:0] {
		MODE_HEADER  = 2'd0,
		MODE_CONTENT = 2'd1,
		MODE_ENDED   = 2'd2,
		MODE_ERROR   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_NAME    = 3'd0,
		KIND_START   = 3'd1,
		KIND_CONTENT = 3'd2,
		KIND_END     = 3'd3,
		KIND_BAD     = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              byte_value;
		logic [OUT_SIZE_W-1:0]   entry_size;
		logic                    last;
	} res_t;

	// Expected characters of the magic field, "ustar " with a trailing space.
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h75;
			3'd1:    c = 8'h73;
			3'd2:    c = 8'h74;
			3'd3:    c = 8'h61;
			3'd4:    c = 8'h72;
			3'd5:    c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/tsep_front.sv @@
`timescale 1ns / 1ps
// Front end: tracks header and content positions, classifies each archive byte
// and produces at most one result beat per byte. Depends on tsep_pkg.
module tsep_front #(
	parameter int SIZE_BITS = tsep_pkg::SIZE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        stream_byte,
	output logic              push,
	output tsep_pkg::res_t    res
);

	localparam int CPOS_W = SIZE_BITS + 1;

	tsep_pkg::mode_t        mode_q, mode_d;
	logic [8:0]             header_pos_q;
	logic                   name_empty_q;
	logic                   magic_match_q;
	logic [SIZE_BITS-1:0]   size_accum_q;
	logic                   size_stopped_q;
	logic                   regular_type_q;
	logic [SIZE_BITS-1:0]   entry_total_q;
	logic [CPOS_W-1:0]      content_pos_q;

	logic [CPOS_W-1:0]      cpos_inc;
	logic [CPOS_W-1:0]      total_ext;
	logic                   header_end;
	logic                   content_done;
	logic                   size_zero;
	logic                   in_size_field;
	logic                   in_magic_field;
	logic [8:0]             magic_idx;
	logic [63:0]            size_wide;

	assign cpos_inc       = content_pos_q + CPOS_W'(1);
	assign total_ext      = {1'b0, entry_total_q};
	assign header_end     = (header_pos_q == tsep_pkg::BLOCK_LAST);
	assign content_done   = (cpos_inc >= total_ext) && (cpos_inc[8:0] == 9'd0);
	assign size_zero      = (size_accum_q == '0);
	assign in_size_field  = (header_pos_q >= tsep_pkg::SIZE_OFF) &&
		(header_pos_q < tsep_pkg::SIZE_END) && !size_stopped_q;
	assign in_magic_field = (header_pos_q >= tsep_pkg::MAGIC_OFF) &&
		(header_pos_q < tsep_pkg::MAGIC_END);
	assign magic_idx      = header_pos_q - tsep_pkg::MAGIC_OFF;
	assign size_wide      = 64'(size_accum_q);

	always_comb begin
		mode_d = mode_q;
		if (take) begin
			unique case (mode_q)
				tsep_pkg::MODE_HEADER: begin
					if (header_end) begin
						if (name_empty_q)
							mode_d = tsep_pkg::MODE_ENDED;
						else if (!magic_match_q)
							mode_d = tsep_pkg::MODE_ERROR;
						else if (!size_zero)
							mode_d = tsep_pkg::MODE_CONTENT;
					end
				end
				tsep_pkg::MODE_CONTENT: begin
					if (content_done)
						mode_d = tsep_pkg::MODE_HEADER;
				end
				default: mode_d = mode_q;
			endcase
		end
	end

	always_comb begin
		push           = 1'b0;
		res.kind       = tsep_pkg::KIND_NAME;
		res.byte_value = 8'd0;
		res.entry_size = '0;
		res.last       = 1'b0;
		if (take) begin
			unique case (mode_q)
				tsep_pkg::MODE_HEADER: begin
					if (header_pos_q < tsep_pkg::NAME_LEN) begin
						push           = 1'b1;
						res.byte_value = stream_byte;
						res.last       = (header_pos_q == tsep_pkg::NAME_LAST);
					end else if (header_end) begin
						if (name_empty_q) begin
							push     = 1'b1;
							res.kind = tsep_pkg::KIND_END;
						end else if (!magic_match_q) begin
							push     = 1'b1;
							res.kind = tsep_pkg::KIND_BAD;
						end else if (regular_type_q) begin
							push           = 1'b1;
							res.kind       = tsep_pkg::KIND_START;
							res.entry_size = size_wide[tsep_pkg::OUT_SIZE_W-1:0];
							res.last       = size_zero;
						end
					end
				end
				tsep_pkg::MODE_CONTENT: begin
					if ((content_pos_q < total_ext) && regular_type_q) begin
						push           = 1'b1;
						res.kind       = tsep_pkg::KIND_CONTENT;
						res.byte_value = stream_byte;
						res.last       = (cpos_inc == total_ext);
					end
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= tsep_pkg::MODE_HEADER;
			header_pos_q   <= 9'd0;
			name_empty_q   <= 1'b0;
			magic_match_q  <= 1'b1;
			size_accum_q   <= '0;
			size_stopped_q <= 1'b0;
			regular_type_q <= 1'b0;
			entry_total_q  <= '0;
			content_pos_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			if (mode_q == tsep_pkg::MODE_HEADER) begin
				if (header_end) begin
					// Fresh header state; the type survives only into a content phase.
					header_pos_q   <= 9'd0;
					name_empty_q   <= 1'b0;
					magic_match_q  <= 1'b1;
					size_accum_q   <= '0;
					size_stopped_q <= 1'b0;
					if (!name_empty_q && magic_match_q && !size_zero) begin
						entry_total_q <= size_accum_q;
						content_pos_q <= '0;
					end else begin
						regular_type_q <= 1'b0;
					end
				end else begin
					header_pos_q <= header_pos_q + 9'd1;
					if (header_pos_q == 9'd0)
						name_empty_q <= (stream_byte == tsep_pkg::CHAR_NUL);
					if (in_size_field) begin
						if (stream_byte == tsep_pkg::CHAR_NUL)
							size_stopped_q <= 1'b1;
						else
							size_accum_q <= {size_accum_q[SIZE_BITS-4:0], 3'b000} +
								SIZE_BITS'(stream_byte) - SIZE_BITS'(tsep_pkg::CHAR_ZERO);
					end
					if (header_pos_q == tsep_pkg::TYPE_OFF)
						regular_type_q <= (stream_byte == tsep_pkg::CHAR_NUL) ||
							(stream_byte == tsep_pkg::CHAR_ZERO);
					if (in_magic_field &&
						(stream_byte != tsep_pkg::magic_char(magic_idx[2:0])))
						magic_match_q <= 1'b0;
				end
			end else if (mode_q == tsep_pkg::MODE_CONTENT) begin
				content_pos_q <= cpos_inc;
				if (content_done) begin
					header_pos_q   <= 9'd0;
					name_empty_q   <= 1'b0;
					magic_match_q  <= 1'b1;
					size_accum_q   <= '0;
					size_stopped_q <= 1'b0;
					regular_type_q <= 1'b0;
				end
			end
		end
	end

	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == tsep_pkg::MODE_ENDED |=> mode_q == tsep_pkg::MODE_ENDED)
		else $error("end of archive state was left");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == tsep_pkg::MODE_ERROR |=> mode_q == tsep_pkg::MODE_ERROR)
		else $error("error state was left");

	a_no_push_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == tsep_pkg::MODE_ENDED || mode_q == tsep_pkg::MODE_ERROR) |-> !push)
		else $error("result produced after the archive stopped");

	a_content_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.kind == tsep_pkg::KIND_CONTENT) |-> (content_pos_q < total_ext))
		else $error("content beat past the entry size");

endmodule

@@ rtl/tsep_queue.sv @@
`timescale 1ns / 1ps
// Small result queue between the front end and the output stage.
// Circular buffer with an occupancy count; depends on tsep_pkg for the beat type.
module tsep_queue #(
	parameter int DEPTH = tsep_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tsep_pkg::res_t    push_data,
	input  logic              pop,
	output tsep_pkg::res_t    head,
	output logic              empty,
	output logic              full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsep_pkg::res_t     mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign empty   = (count_q == CNT_W'(0));
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

@@ rtl/tsep_back.sv @@
`timescale 1ns / 1ps
// Output stage: pulls result beats from the queue into a registered
// valid/ready port. Depends on tsep_pkg for the beat type.
module tsep_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  tsep_pkg::res_t                    q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        kind,
	output logic [7:0]                        byte_value,
	output logic [tsep_pkg::OUT_SIZE_W-1:0]   entry_size,
	output logic                              last
);

	logic            valid_q;
	tsep_pkg::res_t  data_q;

	// Refill whenever the register is empty or its beat leaves this cycle.
	assign q_pop      = !q_empty && (!valid_q || out_ready);
	assign out_valid  = valid_q;
	assign kind       = data_q.kind;
	assign byte_value = data_q.byte_value;
	assign entry_size = data_q.entry_size;
	assign last       = data_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			data_q <= q_head;
	end

endmodule

@@ rtl/tar_stream_entry_parser_unit.sv @@
`timescale 1ns / 1ps
// Top level of the tar stream entry parser: front end, result queue, output stage.
// Depends on tsep_pkg, tsep_front, tsep_queue and tsep_back.
//
// Usage: archive bytes arrive one per beat on in_valid/in_ready/stream_byte.
// Results leave on out_valid/out_ready with kind, byte_value, entry_size, last:
// the 100 name bytes of each header, an entry start for regular files, their
// content bytes, and a final end-of-archive or bad-magic beat. Bytes that
// cause no result (rest of the header, padding, other entry types) are still
// consumed, one per cycle while in_ready is high.
// Throughput is one byte per cycle while the queue is not full; the header position
// counter steps once per header byte and the octal shift-add once per size digit.
// A result is written to the queue at the edge that accepts its byte and then loads into
// the output register when that register is empty or its beat is taken.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue
// and in_ready drops once it is full; nothing is lost or repeated.
// After reset the parser expects the first header byte, the queue and the
// output register are empty. End of archive and bad magic are sticky until
// the next reset; later bytes are accepted and dropped.
module tar_stream_entry_parser_unit #(
	parameter int SIZE_BITS   = tsep_pkg::SIZE_BITS_DEF,
	parameter int QUEUE_DEPTH = tsep_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        stream_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        kind,
	output logic [7:0]                        byte_value,
	output logic [tsep_pkg::OUT_SIZE_W-1:0]   entry_size,
	output logic                              last
);

	logic            take;
	logic            push;
	tsep_pkg::res_t  res;
	tsep_pkg::res_t  q_head;
	logic            q_empty, q_full, q_pop;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	tsep_front #(
		.SIZE_BITS (SIZE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream_byte),
		.push        (push),
		.res         (res)
	);

	tsep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	tsep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.byte_value (byte_value),
		.entry_size (entry_size),
		.last       (last)
	);

endmodule
